>>> sv/crcr_pkg.sv
// shared types and constants of the color ring code reader
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package crcr_pkg;

	localparam int MAX_LINE_PIXELS = 256;
	localparam int MAX_CODES       = 4;

	localparam int HUE_W   = 8;
	localparam int IDX_W   = $clog2(MAX_LINE_PIXELS + 1);
	localparam int RUN_W   = 9;
	localparam int ACC_W   = 2 * MAX_CODES;
	localparam int CNT_W   = $clog2(MAX_CODES + 1);
	localparam int CODE_W  = 8;
	localparam int COUNT_W = 3;
	localparam int REG_W   = 8;
	localparam int CFG_IDX_W = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RED_LOW   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RED_HIGH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN   = 3'd4;

	localparam logic [REG_W-1:0] BLUE_LOW_RST  = 8'd123;
	localparam logic [REG_W-1:0] BLUE_HIGH_RST = 8'd150;
	localparam logic [REG_W-1:0] RED_LOW_RST   = 8'd170;
	localparam logic [REG_W-1:0] RED_HIGH_RST  = 8'd177;
	localparam logic [REG_W-1:0] MIN_RUN_RST   = 8'd3;

	typedef enum logic [1:0] {
		CLS_BLUE    = 2'd0,
		CLS_RED     = 2'd1,
		CLS_INVALID = 2'd2
	} cls_t;

	typedef struct packed {
		logic [REG_W-1:0] blue_low;
		logic [REG_W-1:0] blue_high;
		logic [REG_W-1:0] red_low;
		logic [REG_W-1:0] red_high;
		logic [REG_W-1:0] min_run_exclusive;
	} cfg_t;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic             last_pixel;
	} pix_t;

	typedef struct packed {
		logic [CODE_W-1:0]  packed_code;
		logic [COUNT_W-1:0] code_count;
		logic               center_rejected;
	} res_t;

endpackage

>>> sv/color_ring_code_reader_top.sv
// color ring code reader top: config registers, pixel input register, result register
// depends on crcr_pkg and crcr_line
// a line's last pixel passes the pixel input register, then its result is loaded into
//   the result register and offered there until it is taken
// throughput: one pixel per cycle; input stalls only when a last pixel waits
//   behind a result that has not been taken
// reset: asynchronous, clears line state and handshake flags, loads register defaults
`timescale 1ns / 1ps

module color_ring_code_reader_top import crcr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pix_valid,
	output logic                 pix_stall,
	input  pix_t                 pix,
	output logic                 res_valid,
	input  logic                 res_stall,
	output res_t                 res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data
);

	cfg_t cfg_q;
	logic pix_valid_s1;
	pix_t pix_s1;
	logic res_valid_q;
	res_t res_q;
	res_t line_res;
	logic step;
	logic out_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blue_low          <= BLUE_LOW_RST;
			cfg_q.blue_high         <= BLUE_HIGH_RST;
			cfg_q.red_low           <= RED_LOW_RST;
			cfg_q.red_high          <= RED_HIGH_RST;
			cfg_q.min_run_exclusive <= MIN_RUN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BLUE_LOW:  cfg_q.blue_low          <= cfg_data;
				REG_BLUE_HIGH: cfg_q.blue_high         <= cfg_data;
				REG_RED_LOW:   cfg_q.red_low           <= cfg_data;
				REG_RED_HIGH:  cfg_q.red_high          <= cfg_data;
				REG_MIN_RUN:   cfg_q.min_run_exclusive <= cfg_data;
				default: ;
			endcase
		end
	end

	// only a last pixel needs room in the result register
	assign out_free  = !res_valid_q || !res_stall;
	assign step      = pix_valid_s1 && (!pix_s1.last_pixel || out_free);
	assign pix_stall = pix_valid_s1 && !step;

	crcr_line u_line (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.pix    (pix_s1),
		.cfg    (cfg_q),
		.res    (line_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_s1 <= 1'b0;
		end else if (!pix_stall) begin
			pix_valid_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!pix_stall && pix_valid) begin
			pix_s1 <= pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step && pix_s1.last_pixel) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && pix_s1.last_pixel) begin
			res_q <= line_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// input only backs up behind a pending last pixel and an untaken result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> (pix_valid_s1 && pix_s1.last_pixel && res_valid_q && res_stall))
		else $error("input stalled without a blocked result");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.code_count <= COUNT_W'(MAX_CODES)))
		else $error("code count above limit");

	a_reject_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.center_rejected) |-> (res.packed_code == '0 && res.code_count == '0))
		else $error("rejected line carries codes");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		(step && pix_s1.last_pixel) |=> res_valid)
		else $error("line end did not produce a result");

endmodule

>>> sv/crcr_classify.sv
// hue classifier: blue, red or invalid from two inclusive hue ranges
// depends on crcr_pkg
`timescale 1ns / 1ps

module crcr_classify import crcr_pkg::*; (
	input  logic [HUE_W-1:0] hue,
	input  cfg_t             cfg,
	output cls_t             cls
);

	logic in_blue;
	logic in_red;

	assign in_blue = (cfg.blue_low <= hue) && (hue <= cfg.blue_high);
	assign in_red  = (cfg.red_low <= hue) && (hue <= cfg.red_high);

	// blue wins where the ranges overlap
	always_comb begin
		priority if (in_blue) begin
			cls = CLS_BLUE;
		end else if (in_red) begin
			cls = CLS_RED;
		end else begin
			cls = CLS_INVALID;
		end
	end

endmodule

>>> sv/crcr_line.sv
// per-line state: run counting, code packing, reject flag and line result
// depends on crcr_pkg and crcr_classify
`timescale 1ns / 1ps

module crcr_line import crcr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  pix_t pix,
	input  cfg_t cfg,
	output res_t res
);

	logic [IDX_W-1:0] idx_q, idx_d;
	cls_t             prev_q, prev_d;
	logic [RUN_W-1:0] run_q, run_d;
	logic [ACC_W-1:0] acc_q, acc_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             rej_q, rej_d;
	cls_t             cls;
	logic             active;
	logic             store;

	crcr_classify u_classify (
		.hue (pix.hue),
		.cfg (cfg),
		.cls (cls)
	);

	assign active = !rej_q && (idx_q < IDX_W'(MAX_LINE_PIXELS));
	assign store  = (prev_q != CLS_INVALID)
		&& (run_q > RUN_W'(cfg.min_run_exclusive))
		&& (cnt_q < CNT_W'(MAX_CODES));

	always_comb begin
		idx_d  = idx_q;
		prev_d = prev_q;
		run_d  = run_q;
		acc_d  = acc_q;
		cnt_d  = cnt_q;
		rej_d  = rej_q;
		if (active) begin
			if (idx_q == '0) begin
				if (cls != CLS_BLUE) begin
					rej_d = 1'b1;
				end else begin
					prev_d = cls;
					run_d  = RUN_W'(1);
				end
			end else if (cls == prev_q) begin
				if (run_q != '1) begin
					run_d = run_q + 1'b1;
				end
			end else begin
				// run closed: keep it if long enough, of a valid class and while fewer than MAX_CODES are stored
				if (store) begin
					acc_d = acc_q | (ACC_W'(prev_q) << {cnt_q, 1'b0});
					cnt_d = cnt_q + 1'b1;
				end
				prev_d = cls;
				run_d  = RUN_W'(1);
			end
			idx_d = idx_q + 1'b1;
		end
	end

	always_comb begin
		if (rej_d) begin
			res.packed_code     = '0;
			res.code_count      = '0;
			res.center_rejected = 1'b1;
		end else begin
			res.packed_code     = CODE_W'(acc_d);
			res.code_count      = COUNT_W'(cnt_d);
			res.center_rejected = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			prev_q <= CLS_BLUE;
			run_q  <= '0;
			acc_q  <= '0;
			cnt_q  <= '0;
			rej_q  <= 1'b0;
		end else if (step) begin
			if (pix.last_pixel) begin
				idx_q  <= '0;
				prev_q <= CLS_BLUE;
				run_q  <= '0;
				acc_q  <= '0;
				cnt_q  <= '0;
				rej_q  <= 1'b0;
			end else begin
				idx_q  <= idx_d;
				prev_q <= prev_d;
				run_q  <= run_d;
				acc_q  <= acc_d;
				cnt_q  <= cnt_d;
				rej_q  <= rej_d;
			end
		end
	end

endmodule
